[hdl/scaled_orientation_test_2d_macros.svh]
// assertion macros used by the checker
`ifndef SCALED_ORIENTATION_TEST_2D_MACROS_SVH
`define SCALED_ORIENTATION_TEST_2D_MACROS_SVH

// same-cycle implication
`define SOT_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sot assertion failed");

// next-cycle implication
`define SOT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sot assertion failed");

`endif

[hdl/sot_pkg.sv]
package sot_pkg;

  localparam int DATA_W  = 32;
  localparam int CROSS_W = 64;
  localparam int RAD_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int REM_W   = 35;
  localparam int DREM_W  = ROOT_W + 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-3:0] REG_TOLERANCE = '0;
  localparam logic [DATA_W-1:0]  TOL_RESET     = 32'd429497;

  typedef struct packed {
    logic signed [DATA_W-1:0] first_x;
    logic signed [DATA_W-1:0] first_y;
    logic signed [DATA_W-1:0] second_x;
    logic signed [DATA_W-1:0] second_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] scaled_cross;
    logic                      is_left;
    logic                      is_right;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic                     flg;
  } side_t;

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] u;
    u = DATA_W'(v);
    mag32 = v[DATA_W-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

[hdl/sot_isqrt.sv]
module sot_isqrt import sot_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad_q  [1:ROOT_W];
  logic [REM_W-1:0]  rem_q  [1:ROOT_W];
  logic [ROOT_W-1:0] root_q [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [RAD_W-1:0]  rad_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign rad_p  = rad;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_rest
      assign rad_p  = rad_q[k];
      assign rem_p  = rem_q[k];
      assign root_p = root_q[k];
    end

    assign cur   = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
    assign trial = {{(REM_W-ROOT_W-2){1'b0}}, root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k+1] <= rad_p << 2;
        if (cur >= trial) begin
          rem_q[k+1]  <= cur - trial;
          root_q[k+1] <= {root_p[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= cur;
          root_q[k+1] <= {root_p[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[ROOT_W];

endmodule

[hdl/sot_div.sv]
module sot_div import sot_pkg::*; #(
  parameter int QW = 18,
  parameter int NW = 49
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NW-1:0]     num,
  input  logic [ROOT_W-1:0] den,
  output logic [QW-1:0]     quo
);

  logic [DREM_W-1:0] rem_q [1:QW];
  logic [QW-1:0]     nlo_q [1:QW];
  logic [QW-1:0]     quo_q [1:QW];
  logic [ROOT_W-1:0] den_q [1:QW];

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DREM_W-1:0] rem_p;
    logic [QW-1:0]     nlo_p;
    logic [QW-1:0]     quo_p;
    logic [ROOT_W-1:0] den_p;
    logic [DREM_W-1:0] cur;
    logic [DREM_W-1:0] dd;

    if (j == 0) begin : g_first
      assign rem_p = DREM_W'(num[NW-1:QW]);
      assign nlo_p = num[QW-1:0];
      assign quo_p = '0;
      assign den_p = den;
    end else begin : g_rest
      assign rem_p = rem_q[j];
      assign nlo_p = nlo_q[j];
      assign quo_p = quo_q[j];
      assign den_p = den_q[j];
    end

    assign cur = {rem_p[DREM_W-2:0], nlo_p[QW-1]};
    assign dd  = DREM_W'(den_p);

    always_ff @(posedge clk) begin
      if (en) begin
        nlo_q[j+1] <= nlo_p << 1;
        den_q[j+1] <= den_p;
        if (cur >= dd) begin
          rem_q[j+1] <= cur - dd;
          quo_q[j+1] <= {quo_p[QW-2:0], 1'b1};
        end else begin
          rem_q[j+1] <= cur;
          quo_q[j+1] <= {quo_p[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_q[QW];

endmodule

[hdl/sot_rescale.sv]
module sot_rescale import sot_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] x,
  input  logic signed [DATA_W-1:0] y,
  output logic signed [DATA_W-1:0] xs,
  output logic signed [DATA_W-1:0] ys
);

  localparam int QW    = FRAC_BITS + 2;
  localparam int NW    = FRAC_BITS + 33;
  localparam int SHIFT = RAD_W - 2 * FRAC_BITS;

  // squares
  logic signed [DATA_W-1:0] x1, y1;
  logic [2*DATA_W-1:0]      sqx, sqy;
  logic [DATA_W-1:0]        mx0, my0;

  assign mx0 = mag32(x);
  assign my0 = mag32(y);

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= x;
      y1  <= y;
      sqx <= mx0 * mx0;
      sqy <= my0 * my0;
    end
  end

  // squared length and radicand
  logic [2*DATA_W-1:0] ssum;
  logic [RAD_W-1:0]    rad2;
  side_t               side2;

  assign ssum = sqx + sqy;

  always_ff @(posedge clk) begin
    if (en) begin
      rad2      <= {ssum[2*FRAC_BITS-1:0], {SHIFT{1'b0}}};
      side2.x   <= x1;
      side2.y   <= y1;
      side2.flg <= (ssum != '0) && ((ssum >> (2 * FRAC_BITS)) == '0);
    end
  end

  logic [ROOT_W-1:0] len;

  sot_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad2),
    .root (len)
  );

  side_t side_a [1:ROOT_W];

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_dly_a
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          side_a[k] <= side2;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          side_a[k] <= side_a[k-1];
        end
      end
    end
  end

  // numerators with half divisor for rounding
  logic [DATA_W-1:0] mxa, mya;
  logic [NW-1:0]     numx, numy;
  logic [ROOT_W-1:0] den;
  side_t             side_n;

  assign mxa = mag32(side_a[ROOT_W].x);
  assign mya = mag32(side_a[ROOT_W].y);

  always_ff @(posedge clk) begin
    if (en) begin
      numx   <= NW'({mxa[FRAC_BITS-1:0], 32'b0}) + NW'(len >> 1);
      numy   <= NW'({mya[FRAC_BITS-1:0], 32'b0}) + NW'(len >> 1);
      den    <= len;
      side_n <= side_a[ROOT_W];
    end
  end

  logic [QW-1:0] qx, qy;

  sot_div #(.QW(QW), .NW(NW)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (numx),
    .den (den),
    .quo (qx)
  );

  sot_div #(.QW(QW), .NW(NW)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (numy),
    .den (den),
    .quo (qy)
  );

  side_t side_b [1:QW];

  for (genvar j = 1; j <= QW; j++) begin : g_dly_b
    if (j == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          side_b[j] <= side_n;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          side_b[j] <= side_b[j-1];
        end
      end
    end
  end

  // signed result
  logic signed [DATA_W-1:0] qx_s, qy_s;

  assign qx_s = {{(DATA_W-QW){1'b0}}, qx};
  assign qy_s = {{(DATA_W-QW){1'b0}}, qy};

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_b[QW].flg) begin
        xs <= side_b[QW].x[DATA_W-1] ? -qx_s : qx_s;
        ys <= side_b[QW].y[DATA_W-1] ? -qy_s : qy_s;
      end else begin
        xs <= side_b[QW].x;
        ys <= side_b[QW].y;
      end
    end
  end

endmodule

[hdl/scaled_orientation_test_2d.sv]
// throughput: one item per cycle while res_ready stays high
// latency from item accept to res_valid is mostly set by the 31-stage square root and the FRAC_BITS + 2 stage divider,
// one result bit per stage
// reset clears all valid bits and the output/skid flags; tolerance returns to 429497
module scaled_orientation_test_2d import sot_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               vec_valid,
  output logic               vec_ready,
  input  in_item_t           vec_item,
  output logic               res_valid,
  input  logic               res_ready,
  output out_item_t          res_item
);

  localparam int QW  = FRAC_BITS + 2;
  localparam int LAT = QW + 37;

  // config register
  logic [DATA_W-1:0] tolerance;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_TOLERANCE) ? tolerance : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_TOLERANCE)) begin
      tolerance <= pwdata;
    end
  end

  // pipeline advance
  logic           en;
  logic           skid_valid;
  out_item_t      skid;
  logic [LAT-1:0] vld;

  assign en        = !skid_valid;
  assign vec_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], vec_valid};
    end
  end

  logic signed [DATA_W-1:0] ax, ay, bx, by;

  sot_rescale #(.FRAC_BITS(FRAC_BITS)) u_first (
    .clk (clk),
    .en  (en),
    .x   (vec_item.first_x),
    .y   (vec_item.first_y),
    .xs  (ax),
    .ys  (ay)
  );

  sot_rescale #(.FRAC_BITS(FRAC_BITS)) u_second (
    .clk (clk),
    .en  (en),
    .x   (vec_item.second_x),
    .y   (vec_item.second_y),
    .xs  (bx),
    .ys  (by)
  );

  // products
  logic signed [CROSS_W-1:0] prod_p, prod_q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_p <= ax * by;
      prod_q <= ay * bx;
    end
  end

  // saturated difference
  logic signed [CROSS_W:0]   diff;
  logic signed [CROSS_W-1:0] cross_sat;

  assign diff = {prod_p[CROSS_W-1], prod_p} - {prod_q[CROSS_W-1], prod_q};

  always_ff @(posedge clk) begin
    if (en) begin
      if (diff[CROSS_W] != diff[CROSS_W-1]) begin
        cross_sat <= diff[CROSS_W] ? {1'b1, {(CROSS_W-1){1'b0}}} : {1'b0, {(CROSS_W-1){1'b1}}};
      end else begin
        cross_sat <= diff[CROSS_W-1:0];
      end
    end
  end

  // tolerance compare
  logic signed [CROSS_W:0] cross_x, tol_x, ntol_x;
  out_item_t               item_d;
  logic                    push;

  assign cross_x         = {cross_sat[CROSS_W-1], cross_sat};
  assign tol_x           = {{(CROSS_W+1-DATA_W){1'b0}}, tolerance};
  assign ntol_x          = -tol_x;
  assign item_d.scaled_cross = cross_sat;
  assign item_d.is_left  = cross_x > tol_x;
  assign item_d.is_right = cross_x < ntol_x;
  assign push            = vld[LAT-1] && en;

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res_item   <= skid;
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        res_item  <= item_d;
        res_valid <= 1'b1;
      end else begin
        res_valid <= 1'b0;
      end
    end else if (push) begin
      skid       <= item_d;
      skid_valid <= 1'b1;
    end
  end

endmodule

[hdl/sot_checker.sv]
`include "scaled_orientation_test_2d_macros.svh"

module sot_checker import sot_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      vec_ready,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res_item
);

  `SOT_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_item))
  `SOT_ASSERT_NOW(a_stall_full, clk, rst, !vec_ready, res_valid)
  `SOT_ASSERT_NOW(a_flags_excl, clk, rst, res_valid, !(res_item.is_left && res_item.is_right))
  `SOT_ASSERT_NOW(a_flag_sign, clk, rst, res_valid, (!res_item.is_left || (!res_item.scaled_cross[63] && res_item.scaled_cross != '0)) && (!res_item.is_right || res_item.scaled_cross[63]))

endmodule

bind scaled_orientation_test_2d sot_checker u_sot_checker (.*);

[dv/scaled_orientation_test_2d_tb.sv]
`timescale 1ns / 100ps

module scaled_orientation_test_2d_tb;
  import sot_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int DRAIN_WAIT  = FRAC_BITS + 50;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic vec_valid = 1'b0;
  logic vec_ready;
  in_item_t vec_item = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_item_t res_item;

  in_item_t pending_vecs[$];
  out_item_t expected_cross[$];
  logic [31:0] tol_shadow = TOL_RESET;
  int errors = 0;
  int vecs_sent = 0;
  int results_seen = 0;
  int left_seen = 0;
  int right_seen = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;

  scaled_orientation_test_2d #(.FRAC_BITS(FRAC_BITS)) DUT (.*);

  always #6 clk = ~clk;

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint stretch_comp(longint c, longint unsigned t);
    longint unsigned q;
    q = ((abs64(c) << 32) + (t >> 1)) / t;
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  // short nonzero vectors are stretched to length two
  function automatic void stretch_short(inout longint x, inout longint y);
    longint unsigned sq;
    longint unsigned len;
    sq = abs64(x) * abs64(x) + abs64(y) * abs64(y);
    if (sq == 0 || sq >= (64'd1 << (2 * FRAC_BITS))) return;
    len = root64(sq << (62 - 2 * FRAC_BITS));
    if (len == 0) return;
    x = stretch_comp(x, len);
    y = stretch_comp(y, len);
  endfunction

  function automatic out_item_t orientation_of(in_item_t v);
    longint ax, ay, bx, by, p, q;
    logic signed [64:0] diff;
    longint cr;
    longint tol;
    out_item_t r;
    ax = longint'(v.first_x);
    ay = longint'(v.first_y);
    bx = longint'(v.second_x);
    by = longint'(v.second_y);
    stretch_short(ax, ay);
    stretch_short(bx, by);
    p = ax * by;
    q = ay * bx;
    diff = $signed({p[63], p}) - $signed({q[63], q});
    if (diff > $signed(65'h0_7FFF_FFFF_FFFF_FFFF)) cr = 64'h7FFF_FFFF_FFFF_FFFF;
    else if (diff < $signed(65'h1_8000_0000_0000_0000)) cr = 64'h8000_0000_0000_0000;
    else cr = longint'(diff[63:0]);
    tol = longint'({32'd0, tol_shadow});
    r.scaled_cross = cr;
    r.is_left = cr > tol;
    r.is_right = cr < -tol;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      vec_valid <= 1'b0;
    end else begin
      nv = vec_valid;
      if (vec_valid && vec_ready) begin
        expected_cross.push_back(orientation_of(vec_item));
        vecs_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_vecs.size() > 0) begin
          nv = 1'b1;
          vec_item <= pending_vecs.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      vec_valid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (expected_cross.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_cross.pop_front();
          if (res_item.scaled_cross !== e.scaled_cross)
            report_mismatch($sformatf("scaled_cross %h, want %h",
                                      res_item.scaled_cross, e.scaled_cross));
          if (res_item.is_left !== e.is_left)
            report_mismatch($sformatf("is_left %b, want %b", res_item.is_left, e.is_left));
          if (res_item.is_right !== e.is_right)
            report_mismatch($sformatf("is_right %b, want %b", res_item.is_right, e.is_right));
          left_seen += e.is_left;
          right_seen += e.is_right;
        end
      end
      if (cycles % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: res_ready <= 1'b1;
        1: res_ready <= ($urandom_range(0, 3) != 0);
        2: res_ready <= ($urandom_range(0, 3) == 0);
        default: res_ready <= cycles[2];
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_cross.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_tolerance(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TOLERANCE, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tol_shadow = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_vecs.size() > 0 || vec_valid || expected_cross.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_comp(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 131070)) - 65535);
      2: return 32'($signed($urandom_range(0, 510)) - 255);
      default: return 32'($signed($urandom_range(0, 8388606)) - 4194303);
    endcase
  endfunction

  function automatic in_item_t random_vecs();
    in_item_t v;
    int ma, mb;
    ma = $urandom_range(0, 3);
    mb = $urandom_range(0, 3);
    v.first_x = pick_comp(ma);
    v.first_y = pick_comp(ma);
    if ($urandom_range(0, 4) == 0) begin
      // nearly collinear pair
      v.second_x = v.first_x + $signed(32'($urandom_range(0, 4)) - 2);
      v.second_y = v.first_y + $signed(32'($urandom_range(0, 4)) - 2);
    end else begin
      v.second_x = pick_comp(mb);
      v.second_y = pick_comp(mb);
    end
    return v;
  endfunction

  function automatic in_item_t mk(logic [31:0] ax, logic [31:0] ay,
                                  logic [31:0] bx, logic [31:0] by);
    in_item_t v;
    v.first_x = ax;
    v.first_y = ay;
    v.second_x = bx;
    v.second_y = by;
    return v;
  endfunction

  initial begin
    logic [31:0] tol_list[5];
    tol_list = '{TOL_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1, $urandom()};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tol_list[ph]);
      if (ph == 0 || ph == 1) begin
        pending_vecs.push_back(mk(0, 0, 0, 0));
        pending_vecs.push_back(mk(0, 0, 32'h0001_0000, 32'h0002_0000));
        pending_vecs.push_back(mk(32'h0001_0000, 0, 0, 32'h0001_0000));
        pending_vecs.push_back(mk(0, 32'h0001_0000, 32'h0001_0000, 0));
        pending_vecs.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        pending_vecs.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_vecs.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_vecs.push_back(mk(1, 0, 0, 1));
        pending_vecs.push_back(mk(32'hFFFF_FFFF, 1, 1, 1));
        pending_vecs.push_back(mk(32'h0000_FFFF, 0, 0, 32'hFFFF_0001));
        pending_vecs.push_back(mk(32'h0000_B504, 32'h0000_B504, 32'hFFFF_4AFC, 32'h0000_B505));
        pending_vecs.push_back(mk(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8001));
        pending_vecs.push_back(mk(32'h0001_0000, 32'h0000_0001, 32'h0001_0000, 32'h0000_0002));
        pending_vecs.push_back(mk(32'h8000_0000, 0, 0, 0));
        pending_vecs.push_back(mk(32'hFFFF_0000, 0, 0, 32'h0000_0100));
      end
      for (int i = 0; i < 115; i++) pending_vecs.push_back(random_vecs());
      drain();
    end

    $display("sent %0d vector pairs over 5 tolerance settings (0, 1, max, default, random)",
             vecs_sent);
    $display("checked %0d results: %0d left, %0d right", results_seen, left_seen, right_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/sot_pkg.sv
hdl/sot_isqrt.sv
hdl/sot_div.sv
hdl/sot_rescale.sv
hdl/scaled_orientation_test_2d.sv
hdl/sot_checker.sv
dv/scaled_orientation_test_2d_tb.sv
